// ----- rtl/core/rsst_pkg.sv -----
package rsst_pkg;

    localparam int NUM_ELEMENTS = 1024;
    localparam int NODE_CNT     = 2 * NUM_ELEMENTS;
    localparam int IDX_W        = $clog2(NUM_ELEMENTS);
    localparam int NODE_W       = $clog2(NODE_CNT);
    localparam int DATA_W       = 32;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic [NODE_W-1:0] node_addr_t;
    typedef logic [DATA_W-1:0] word_t;

    typedef struct packed {
        logic       en;
        node_addr_t addr;
        word_t      data;
    } mem_wr_t;

    typedef struct packed {
        logic       en;
        node_addr_t addr;
    } mem_rd_t;

endpackage

// ----- rtl/core/range_sum_segment_tree.sv -----
// Range-sum tree over 1024 signed 32-bit elements with point writes.
// Input channel: in_valid / in_stall with kind, position, new_value,
// range_low, range_high. A transaction is taken when in_valid is high and
// in_stall is low. kind 0 writes new_value at position and gives no result;
// kind 1 returns the wrapped sum of elements range_low..range_high (range_high
// clipped to the array, empty range gives 0) on the output channel
// out_valid / out_stall / range_sum.
// The tree nodes live in one 2048-word RAM with a registered read port and a
// separate write port. A write stores the leaf, then does one read-add-write
// step per tree level. A query walks the tree level by level, with at most
// one RAM read each for the left and right boundary per level, then loads
// the output register. One transaction is worked on at a time; in_stall is
// high while busy.
// After reset the RAM is cleared one word per cycle, with in_stall high. A
// finished sum waits in the output register while out_stall is high; the
// block then holds before loading the next result.
module range_sum_segment_tree
    import rsst_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     kind,
    input  logic [IDX_W-1:0]         position,
    input  logic signed [DATA_W-1:0] new_value,
    input  logic [IDX_W-1:0]         range_low,
    input  logic [IDX_W-1:0]         range_high,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] range_sum
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_WUP    = 3'd2;
    localparam logic [2:0] ST_QLOOP  = 3'd3;
    localparam logic [2:0] ST_QRIGHT = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    localparam node_addr_t LAST_NODE = NODE_W'(NODE_CNT - 1);
    localparam node_addr_t ROOT_NODE = NODE_W'(1);

    logic [2:0]        state_reg, state_next;
    node_addr_t        clr_reg, clr_next;
    node_addr_t        child_reg, child_next;
    word_t             cur_reg, cur_next;
    logic [NODE_W:0]   l_reg, l_next;
    logic [NODE_W:0]   r_reg, r_next;
    word_t             acc_reg, acc_next;
    logic              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    word_t             range_sum_reg, range_sum_next;

    mem_wr_t           wr;
    mem_rd_t           rd;
    word_t             rd_data;

    node_addr_t        leaf;
    node_addr_t        parent;
    word_t             sum;
    word_t             acc_add;
    logic [IDX_W-1:0]  hi_clip;
    logic [NODE_W:0]   r_dec;

    rsst_mem u_mem
    (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    assign leaf    = NODE_W'(NUM_ELEMENTS) + NODE_W'(position);
    assign parent  = child_reg >> 1;
    assign sum     = cur_reg + rd_data;
    assign acc_add = pend_reg ? (acc_reg + rd_data) : acc_reg;
    assign hi_clip = (32'(range_high) >= NUM_ELEMENTS) ? IDX_W'(NUM_ELEMENTS - 1) : range_high;
    assign r_dec   = r_reg - (NODE_W+1)'(1);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        child_next     = child_reg;
        cur_next       = cur_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        acc_next       = acc_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        range_sum_next = range_sum_reg;
        wr             = '0;
        rd             = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                wr.en    = 1'b1;
                wr.addr  = clr_reg;
                clr_next = clr_reg + NODE_W'(1);
                if (clr_reg == LAST_NODE)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind == KIND_WRITE)
                    begin
                        if (32'(position) < NUM_ELEMENTS)
                        begin
                            wr.en      = 1'b1;
                            wr.addr    = leaf;
                            wr.data    = word_t'(new_value);
                            rd.en      = 1'b1;
                            rd.addr    = {leaf[NODE_W-1:1], ~leaf[0]};
                            child_next = leaf;
                            cur_next   = word_t'(new_value);
                            state_next = ST_WUP;
                        end
                    end
                    else
                    begin
                        acc_next  = '0;
                        pend_next = 1'b0;
                        if (32'(range_low) >= NUM_ELEMENTS || range_low > hi_clip)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            l_next     = (NODE_W+1)'(NUM_ELEMENTS) + (NODE_W+1)'(range_low);
                            r_next     = (NODE_W+1)'(NUM_ELEMENTS) + (NODE_W+1)'(hi_clip)
                                         + (NODE_W+1)'(1);
                            state_next = ST_QLOOP;
                        end
                    end
                end
            end
            ST_WUP:
            begin
                wr.en      = 1'b1;
                wr.addr    = parent;
                wr.data    = sum;
                cur_next   = sum;
                child_next = parent;
                if (parent == ROOT_NODE)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd.en   = 1'b1;
                    rd.addr = {parent[NODE_W-1:1], ~parent[0]};
                end
            end
            ST_QLOOP:
            begin
                acc_next  = acc_add;
                pend_next = 1'b0;
                if (l_reg >= r_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    if (l_reg[0])
                    begin
                        rd.en     = 1'b1;
                        rd.addr   = l_reg[NODE_W-1:0];
                        pend_next = 1'b1;
                        l_next    = l_reg + (NODE_W+1)'(1);
                    end
                    state_next = ST_QRIGHT;
                end
            end
            ST_QRIGHT:
            begin
                acc_next  = acc_add;
                pend_next = r_reg[0];
                if (r_reg[0])
                begin
                    rd.en   = 1'b1;
                    rd.addr = r_dec[NODE_W-1:0];
                    r_next  = r_dec >> 1;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                l_next     = l_reg >> 1;
                state_next = ST_QLOOP;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    range_sum_next = acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        child_reg     <= child_next;
        cur_reg       <= cur_next;
        l_reg         <= l_next;
        r_reg         <= r_next;
        acc_reg       <= acc_next;
        range_sum_reg <= range_sum_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign range_sum = signed'(range_sum_reg);

endmodule

// ----- rtl/core/rsst_mem.sv -----
module rsst_mem
    import rsst_pkg::*;
(
    input  logic    clk,
    input  mem_wr_t wr,
    input  mem_rd_t rd,
    output word_t   rd_data
);

    word_t mem [NODE_CNT];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule
